// ===== rtl/cdbl_pkg.sv =====
// ----------------------------------------------------------------------------
// cdbl_pkg
// Shared types and constants of the constant database lookup unit.
// ----------------------------------------------------------------------------
package cdbl_pkg;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_APPEND = 2'd1,
        OP_LOOKUP = 2'd2
    } t_op;

    // Result status codes.
    localparam logic [1:0] ST_NOT_FOUND = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;
    localparam logic [1:0] ST_FORMAT    = 2'd3;

    // Hash seed, bytes per head entry or slot, and bound arithmetic width.
    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam int          SLOT_BYTES = 8;
    localparam int          BW = 36;

    // One command passed from the front part to the back part.
    typedef struct packed {
        t_op         op;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_cmd;

endpackage

// ===== rtl/cdbl_front.sv =====
// ----------------------------------------------------------------------------
// cdbl_front
// Accepts input items, drops unused operation codes and queues the rest in a
// two-entry command queue for the back part.
// ----------------------------------------------------------------------------
module cdbl_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_operation,
    input  logic [15:0]         i_image_address,
    input  logic [7:0]          i_data_byte,
    output logic                o_stall,
    output cdbl_pkg::t_cmd      o_cmd,
    output logic                o_cmd_valid,
    input  logic                i_cmd_pop
);

    cdbl_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_take;
    logic           w_push;
    logic           w_pop;

    // The queue is full when both entries hold commands.
    assign o_stall     = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Only known operation codes enter the queue.
    assign w_take = i_valid && !o_stall;
    assign w_push = w_take && (i_operation inside {cdbl_pkg::OP_WRITE, cdbl_pkg::OP_APPEND,
                                                   cdbl_pkg::OP_LOOKUP});
    assign w_pop  = i_cmd_pop && o_cmd_valid;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{op: cdbl_pkg::t_op'(i_operation), addr: i_image_address,
                           data: i_data_byte};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/cdbl_back.sv =====
// ----------------------------------------------------------------------------
// cdbl_back
// Carries out queued commands: image writes, key appends with hashing, and
// the lookup sequencer with its image memory, key buffer and divider.
// ----------------------------------------------------------------------------
module cdbl_back #(
    parameter int IMAGE_BYTES = 65536,
    parameter int MAX_KEY     = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  cdbl_pkg::t_cmd      i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic [15:0]         o_value_offset,
    output logic [15:0]         o_value_length
);

    localparam int AW  = $clog2(IMAGE_BYTES);
    localparam int KW  = $clog2(MAX_KEY + 1);
    localparam int KAW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int CW  = (KW > 5) ? KW : 5;
    localparam int BW  = cdbl_pkg::BW;
    localparam logic [BW-1:0] IMG = BW'(IMAGE_BYTES);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_RD8     = 10'b00_0000_0010,
        S_HEAD    = 10'b00_0000_0100,
        S_DIV     = 10'b00_0000_1000,
        S_SLOT    = 10'b00_0001_0000,
        S_SLOTCHK = 10'b00_0010_0000,
        S_REC     = 10'b00_0100_0000,
        S_CMP     = 10'b00_1000_0000,
        S_VALCHK  = 10'b01_0000_0000,
        S_RES     = 10'b10_0000_0000
    } t_state;

    t_state         r_state;
    t_state         r_ret;
    logic [CW-1:0]  r_cnt;
    logic [AW-1:0]  r_base;
    logic [63:0]    r_word;
    logic           r_ready;
    logic [KW-1:0]  r_key_len;
    logic           r_key_ovf;
    logic [31:0]    r_run_hash;
    logic [31:0]    r_h;
    logic [KW-1:0]  r_lkey;
    logic [31:0]    r_tpos;
    logic [31:0]    r_tlen;
    logic [31:0]    r_idx;
    logic [31:0]    r_iter;
    logic [31:0]    r_rpos;
    logic [23:0]    r_dvd;
    logic           r_mis;
    logic [1:0]     r_res_st;
    logic [15:0]    r_res_off;
    logic [15:0]    r_res_len;
    logic           r_ovalid;
    logic [1:0]     r_ost;
    logic [15:0]    r_ooff;
    logic [15:0]    r_olen;

    logic [7:0]     r_mem [IMAGE_BYTES];
    logic [7:0]     r_kbuf [MAX_KEY];
    logic [7:0]     r_rdata;
    logic [7:0]     r_kdata;

    logic           w_pop;
    logic           w_mem_we;
    logic [BW-1:0]  w_waddr;
    logic           w_key_we;
    logic [AW-1:0]  w_raddr;
    logic [32:0]    w_div_t;
    logic [32:0]    w_div_d;
    logic [31:0]    w_iter_n;
    logic [31:0]    w_idx_n;
    logic           w_mis_now;
    logic [BW-1:0]  w_rec_key_end;
    logic [BW-1:0]  w_val_end;
    logic           w_out_free;

    assign w_pop     = (r_state == S_IDLE) && i_cmd_valid;
    assign o_cmd_pop = w_pop;

    // Image writes beyond the memory are dropped.
    assign w_waddr  = BW'(i_cmd.addr);
    assign w_mem_we = w_pop && (i_cmd.op == cdbl_pkg::OP_WRITE) && (w_waddr < IMG);
    assign w_key_we = w_pop && (i_cmd.op == cdbl_pkg::OP_APPEND)
                      && (r_key_len < KW'(MAX_KEY));
    assign w_raddr  = r_base + AW'(r_cnt);

    // Image memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_waddr[AW-1:0]] <= i_cmd.data;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Key buffer: written on appends, read during the key compare.
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_kbuf[r_key_len[KAW-1:0]] <= i_cmd.data;
        end
        r_kdata <= r_kbuf[r_cnt[KAW-1:0]];
    end

    // One restoring division step for the starting slot.
    assign w_div_t = {r_idx, r_dvd[23]};
    assign w_div_d = w_div_t - {1'b0, r_tlen};

    // Advance to the next probe, wrapping inside the slot table.
    assign w_iter_n = r_iter + 32'd1;
    assign w_idx_n  = ((r_idx + 32'd1) == r_tlen) ? 32'd0 : (r_idx + 32'd1);

    // Compare outcome including the byte arriving this cycle.
    assign w_mis_now = r_mis || ((r_cnt != '0) && (r_rdata != r_kdata));

    // End of the stored key and of the value.
    assign w_rec_key_end = BW'(r_rpos) + BW'(cdbl_pkg::SLOT_BYTES) + BW'(r_word[31:0]);
    assign w_val_end     = w_rec_key_end + BW'(r_word[63:32]);

    assign w_out_free = !r_ovalid || !i_stall;

    // Lookup sequencer, key state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_ready    <= 1'b0;
            r_key_len  <= '0;
            r_key_ovf  <= 1'b0;
            r_run_hash <= cdbl_pkg::HASH_SEED;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ready <= i_cfg_wdata;
            end
            // A new result refills the output register as the old one leaves.
            if ((r_state == S_RES) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_pop && (i_cmd.op == cdbl_pkg::OP_APPEND)) begin
                        if (w_key_we) begin
                            r_key_len <= r_key_len + KW'(1);
                        end else begin
                            r_key_ovf <= 1'b1;
                        end
                        r_run_hash <= ((r_run_hash << 5) + r_run_hash) ^ 32'(i_cmd.data);
                    end else if (w_pop && (i_cmd.op == cdbl_pkg::OP_LOOKUP)) begin
                        r_h        <= r_run_hash;
                        r_lkey     <= r_key_len;
                        r_key_len  <= '0;
                        r_key_ovf  <= 1'b0;
                        r_run_hash <= cdbl_pkg::HASH_SEED;
                        r_res_off  <= '0;
                        r_res_len  <= '0;
                        if (!r_ready) begin
                            r_res_st <= cdbl_pkg::ST_NOT_FOUND;
                            r_state  <= S_RES;
                        end else if (r_key_ovf) begin
                            r_res_st <= cdbl_pkg::ST_TOO_LONG;
                            r_state  <= S_RES;
                        end else begin
                            r_base  <= AW'({r_run_hash[7:0], 3'b000});
                            r_cnt   <= '0;
                            r_ret   <= S_HEAD;
                            r_state <= S_RD8;
                        end
                    end
                end
                // Read eight bytes, little-endian, into the word register.
                S_RD8: begin
                    if (r_cnt != '0) begin
                        r_word <= {r_rdata, r_word[63:8]};
                    end
                    if (r_cnt == CW'(8)) begin
                        r_state <= r_ret;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                // Head entry: slot table position and count.
                S_HEAD: begin
                    r_tpos <= r_word[31:0];
                    r_tlen <= r_word[63:32];
                    if (r_word[63:32] == 32'd0) begin
                        r_res_st <= cdbl_pkg::ST_NOT_FOUND;
                        r_state  <= S_RES;
                    end else if ((BW'(r_word[31:0]) + {1'b0, r_word[63:32], 3'b000}) > IMG) begin
                        r_res_st <= cdbl_pkg::ST_FORMAT;
                        r_state  <= S_RES;
                    end else begin
                        r_dvd   <= r_h[31:8];
                        r_idx   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                // Remainder of the upper hash bits by the slot count.
                S_DIV: begin
                    r_dvd <= {r_dvd[22:0], 1'b0};
                    if (!w_div_d[32]) begin
                        r_idx <= w_div_d[31:0];
                    end else begin
                        r_idx <= w_div_t[31:0];
                    end
                    if (r_cnt == CW'(23)) begin
                        r_iter  <= '0;
                        r_state <= S_SLOT;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_SLOT: begin
                    r_base  <= AW'(BW'(r_tpos) + {1'b0, r_idx, 3'b000});
                    r_cnt   <= '0;
                    r_ret   <= S_SLOTCHK;
                    r_state <= S_RD8;
                end
                // Slot: stored hash and record position.
                S_SLOTCHK: begin
                    r_rpos <= r_word[63:32];
                    if (r_word[63:32] == 32'd0) begin
                        r_res_st <= cdbl_pkg::ST_NOT_FOUND;
                        r_state  <= S_RES;
                    end else if (r_word[31:0] != r_h) begin
                        if (w_iter_n == r_tlen) begin
                            r_res_st <= cdbl_pkg::ST_NOT_FOUND;
                            r_state  <= S_RES;
                        end else begin
                            r_iter  <= w_iter_n;
                            r_idx   <= w_idx_n;
                            r_state <= S_SLOT;
                        end
                    end else if ((BW'(r_word[63:32]) + BW'(cdbl_pkg::SLOT_BYTES)) > IMG) begin
                        r_res_st <= cdbl_pkg::ST_FORMAT;
                        r_state  <= S_RES;
                    end else begin
                        r_base  <= AW'(r_word[63:32]);
                        r_cnt   <= '0;
                        r_ret   <= S_REC;
                        r_state <= S_RD8;
                    end
                end
                // Record header: key length and value length.
                S_REC: begin
                    if (r_word[31:0] != 32'(r_lkey)) begin
                        if (w_iter_n == r_tlen) begin
                            r_res_st <= cdbl_pkg::ST_NOT_FOUND;
                            r_state  <= S_RES;
                        end else begin
                            r_iter  <= w_iter_n;
                            r_idx   <= w_idx_n;
                            r_state <= S_SLOT;
                        end
                    end else if (w_rec_key_end > IMG) begin
                        r_res_st <= cdbl_pkg::ST_FORMAT;
                        r_state  <= S_RES;
                    end else if (r_lkey == '0) begin
                        r_state <= S_VALCHK;
                    end else begin
                        r_base  <= AW'(BW'(r_rpos) + BW'(cdbl_pkg::SLOT_BYTES));
                        r_cnt   <= '0;
                        r_mis   <= 1'b0;
                        r_state <= S_CMP;
                    end
                end
                // Byte-wise key compare, one byte a cycle.
                S_CMP: begin
                    if (r_cnt == CW'(r_lkey)) begin
                        if (w_mis_now) begin
                            if (w_iter_n == r_tlen) begin
                                r_res_st <= cdbl_pkg::ST_NOT_FOUND;
                                r_state  <= S_RES;
                            end else begin
                                r_iter  <= w_iter_n;
                                r_idx   <= w_idx_n;
                                r_state <= S_SLOT;
                            end
                        end else begin
                            r_state <= S_VALCHK;
                        end
                    end else begin
                        r_mis <= w_mis_now;
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_VALCHK: begin
                    if (w_val_end > IMG) begin
                        r_res_st <= cdbl_pkg::ST_FORMAT;
                    end else begin
                        r_res_st  <= cdbl_pkg::ST_FOUND;
                        r_res_off <= w_rec_key_end[15:0];
                        r_res_len <= r_word[47:32];
                    end
                    r_state <= S_RES;
                end
                // Hand the result to the output register once it is free.
                S_RES: begin
                    if (w_out_free) begin
                        r_ost    <= r_res_st;
                        r_ooff   <= r_res_off;
                        r_olen   <= r_res_len;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ost;
    assign o_value_offset = r_ooff;
    assign o_value_length = r_olen;

endmodule

// ===== rtl/constant_db_hash_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// constant_db_hash_lookup_unit
// Looks keys up in a constant database image held in on-chip memory.
// ----------------------------------------------------------------------------
// Image writes and key appends are carried out by the back part while it is
// idle, so they stream at one per cycle while no lookup is in progress. A
// lookup leaves the queue, reads the head entry over the single image read
// port, runs a remainder divider for the starting slot, then reads each
// probed slot, reads the record header on a hash match, compares the key
// byte by byte and checks the value bound; a final step hands the result to
// the output register. A two-entry command queue lets input transfers
// continue while a result waits to be taken.
module constant_db_hash_lookup_unit #(
    parameter int IMAGE_BYTES = 65536,
    parameter int MAX_KEY     = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_image_address,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_value_offset,
    output logic [15:0] o_value_length
);

    cdbl_pkg::t_cmd w_cmd;
    logic           w_cmd_valid;
    logic           w_cmd_pop;

    // Front part: input transfers and command queue.
    cdbl_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_operation     (i_operation),
        .i_image_address (i_image_address),
        .i_data_byte     (i_data_byte),
        .o_stall         (o_stall),
        .o_cmd           (w_cmd),
        .o_cmd_valid     (w_cmd_valid),
        .i_cmd_pop       (w_cmd_pop)
    );

    // Back part: memories and lookup sequencer.
    cdbl_back #(
        .IMAGE_BYTES (IMAGE_BYTES),
        .MAX_KEY     (MAX_KEY)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (w_cmd),
        .i_cmd_valid    (w_cmd_valid),
        .o_cmd_pop      (w_cmd_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_value_offset (o_value_offset),
        .o_value_length (o_value_length)
    );

endmodule

// ===== rtl/cdbl_checker.sv =====
// ----------------------------------------------------------------------------
// cdbl_checker
// Port-level checks of the lookup unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module cdbl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [15:0] o_value_offset,
    input logic [15:0] o_value_length
);

    // A stalled result stays presented and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_value_offset) && $stable(o_value_length))
        else $error("stalled result changed");

    // Any result other than found carries zero offset and length.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != cdbl_pkg::ST_FOUND)
            |-> (o_value_offset == 16'd0) && (o_value_length == 16'd0))
        else $error("non-found result carries value fields");

    // No result is presented in the cycle after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind constant_db_hash_lookup_unit cdbl_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_value_offset (o_value_offset),
    .o_value_length (o_value_length)
);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for constant_db_hash_lookup_unit. A small constant
// database is built in memory, loaded through image write transfers and then
// searched with hits, misses, over-long keys and deliberately damaged tables.
// Every lookup is predicted here and its result compared field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int KEY_MAX    = 64;
    localparam int NUM_KEYS   = 20;
    localparam int NUM_ENTS   = 2 * NUM_KEYS;
    localparam int SETTLE     = 400;
    localparam int IDLE_LIMIT = 5000;
    localparam int PROBE_KEY  = 1;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] offset;
        logic [15:0] length;
    } t_lookup_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_operation = cdbl_pkg::OP_WRITE;
    logic [15:0] i_image_address = 16'd0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_value_offset;
    logic [15:0] o_value_length;

    // Predicted block state.
    logic [7:0]  img_mem [0:65535];
    logic [7:0]  key_buf [0:KEY_MAX-1];
    int unsigned key_len;
    bit          key_ovf;
    bit [31:0]   key_hash;
    bit          image_ready;

    // Planned database image.
    logic [7:0]  plan_mem [0:65535];
    bit          plan_set [0:65535];
    logic [7:0]  ent_bytes [0:NUM_ENTS-1][0:KEY_MAX];
    int unsigned ent_len [0:NUM_ENTS-1];
    bit [31:0]   ent_hash [0:NUM_ENTS-1];
    int unsigned ent_slot [0:NUM_ENTS-1];
    int unsigned ent_rec [0:NUM_ENTS-1];
    int unsigned num_ents;

    t_lookup_answer lookup_answers [$];
    t_lookup_answer got;
    int  fails = 0;
    int  items_sent = 0;
    bit  quiet = 1'b0;
    int  hold_req = 0;
    int  idle_cycles = 0;

    constant_db_hash_lookup_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation), .i_image_address(i_image_address),
        .i_data_byte(i_data_byte),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_value_offset(o_value_offset),
        .o_value_length(o_value_length)
    );

    always #5 i_clk = ~i_clk;

    // Little-endian word of the predicted image.
    function automatic bit [31:0] image_word(longint unsigned a);
        return {img_mem[a+3], img_mem[a+2], img_mem[a+1], img_mem[a]};
    endfunction

    // Expected answer of a lookup of the buffered key.
    function automatic t_lookup_answer predict_lookup();
        t_lookup_answer r;
        longint unsigned head, tpos, tlen, start, slot, rpos, klen, dlen;
        bit [31:0] shash;
        bit same;
        r.status = cdbl_pkg::ST_NOT_FOUND;
        r.offset = 16'd0;
        r.length = 16'd0;
        if (!image_ready) return r;
        if (key_ovf) begin
            r.status = cdbl_pkg::ST_TOO_LONG;
            return r;
        end
        head = longint'(key_hash % 256) * cdbl_pkg::SLOT_BYTES;
        tpos = image_word(head);
        tlen = image_word(head + 4);
        if (tlen == 0) return r;
        if (tpos + tlen * cdbl_pkg::SLOT_BYTES > 65536) begin
            r.status = cdbl_pkg::ST_FORMAT;
            return r;
        end
        start = longint'(key_hash >> 8) % tlen;
        for (longint unsigned i = 0; i < tlen; i++) begin
            slot  = tpos + ((start + i) % tlen) * cdbl_pkg::SLOT_BYTES;
            shash = image_word(slot);
            rpos  = image_word(slot + 4);
            if (rpos == 0) return r;
            if (shash == key_hash) begin
                if (rpos + 8 > 65536) begin
                    r.status = cdbl_pkg::ST_FORMAT;
                    return r;
                end
                klen = image_word(rpos);
                dlen = image_word(rpos + 4);
                if (klen == key_len) begin
                    if (rpos + 8 + klen > 65536) begin
                        r.status = cdbl_pkg::ST_FORMAT;
                        return r;
                    end
                    same = 1'b1;
                    for (longint unsigned j = 0; j < klen; j++)
                        if (img_mem[rpos+8+j] != key_buf[j]) same = 1'b0;
                    if (same) begin
                        if (rpos + 8 + klen + dlen > 65536) begin
                            r.status = cdbl_pkg::ST_FORMAT;
                            return r;
                        end
                        r.status = cdbl_pkg::ST_FOUND;
                        r.offset = 16'(rpos + 8 + klen);
                        r.length = 16'(dlen);
                        return r;
                    end
                end
            end
        end
        return r;
    endfunction

    // Advances the predicted state by one accepted transfer.
    function automatic void predict_item(logic [1:0] op, logic [15:0] a, logic [7:0] d);
        case (op)
            cdbl_pkg::OP_WRITE: begin
                img_mem[a] = d;
            end
            cdbl_pkg::OP_APPEND: begin
                if (key_len < KEY_MAX) begin
                    key_buf[key_len] = d;
                    key_len++;
                end else begin
                    key_ovf = 1'b1;
                end
                key_hash = (key_hash * 32'd33) ^ {24'd0, d};
            end
            cdbl_pkg::OP_LOOKUP: begin
                lookup_answers.push_back(predict_lookup());
                key_len  = 0;
                key_ovf  = 1'b0;
                key_hash = cdbl_pkg::HASH_SEED;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic bit [31:0] bytes_hash(int e);
        bit [31:0] h;
        h = cdbl_pkg::HASH_SEED;
        for (int i = 0; i < ent_len[e]; i++) h = (h * 32'd33) ^ {24'd0, ent_bytes[e][i]};
        return h;
    endfunction

    function automatic void plan_put(int unsigned a, bit [31:0] v);
        for (int i = 0; i < 4; i++) begin
            plan_mem[a+i] = v[8*i +: 8];
            plan_set[a+i] = 1'b1;
        end
    endfunction

    function automatic bit [31:0] plan_word(int unsigned a);
        return {plan_mem[a+3], plan_mem[a+2], plan_mem[a+1], plan_mem[a]};
    endfunction

    // Builds the database: random keys, some decoys sharing a key's hash, odd
    // buckets with full slot tables and even buckets with half-empty ones.
    function automatic void build_plan();
        int unsigned cnt [0:255];
        int unsigned tpos [0:255];
        int unsigned tlen [0:255];
        int unsigned pos, rec, s, b, e;
        for (int i = 0; i < 65536; i++) plan_set[i] = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            ent_len[k] = (k == 0) ? 0 : (k == PROBE_KEY) ? KEY_MAX : $urandom_range(1, 16);
            for (int i = 0; i <= KEY_MAX; i++) ent_bytes[k][i] = 8'($urandom);
            ent_hash[k] = bytes_hash(k);
        end
        // Decoys carry the hash of a real key but a different key.
        num_ents = NUM_KEYS;
        for (int k = 1; k < NUM_KEYS; k++) begin
            if (k % 3 != 0) begin
                ent_bytes[num_ents] = ent_bytes[k];
                ent_len[num_ents]   = ent_len[k];
                if (k % 3 == 1) ent_bytes[num_ents][0] = ent_bytes[k][0] ^ 8'h01;
                else ent_len[num_ents] = ent_len[k] + 1;
                ent_hash[num_ents] = ent_hash[k];
                num_ents++;
            end
        end
        for (int i = 0; i < 256; i++) cnt[i] = 0;
        for (int i = 0; i < num_ents; i++) cnt[ent_hash[i] % 256]++;
        pos = 2048;
        for (int i = 0; i < 256; i++) begin
            tlen[i] = (i % 2 == 1) ? cnt[i] : 2 * cnt[i];
            tpos[i] = (tlen[i] == 0) ? 0 : pos;
            plan_put(i * 8, tpos[i]);
            plan_put(i * 8 + 4, tlen[i]);
            for (int j = 0; j < 2 * tlen[i]; j++) plan_put(pos + 4 * j, 32'd0);
            pos += 8 * tlen[i];
        end
        rec = pos;
        // Decoys go in first so that they take the slots a real key starts at.
        for (int n = 0; n < num_ents; n++) begin
            e = (n < num_ents - NUM_KEYS) ? NUM_KEYS + n : n - (num_ents - NUM_KEYS);
            b = ent_hash[e] % 256;
            s = (ent_hash[e] >> 8) % tlen[b];
            while (plan_word(tpos[b] + 8 * s + 4) != 0) s = (s + 1) % tlen[b];
            ent_slot[e] = tpos[b] + 8 * s;
            ent_rec[e]  = rec;
            plan_put(ent_slot[e], ent_hash[e]);
            plan_put(ent_slot[e] + 4, rec);
            plan_put(rec, ent_len[e]);
            plan_put(rec + 4, $urandom_range(0, 200));
            for (int i = 0; i < ent_len[e]; i++) begin
                plan_mem[rec+8+i] = ent_bytes[e][i];
                plan_set[rec+8+i] = 1'b1;
            end
            rec += 8 + ent_len[e] + plan_word(rec + 4);
        end
    endfunction

    // Offers one item and waits for its transfer, with an occasional gap first.
    task automatic send_item(logic [1:0] op, logic [15:0] a, logic [7:0] d);
        if (!quiet && $urandom_range(0, 15) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_image_address <= a;
        i_data_byte     <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_item(op, a, d);
        items_sent++;
    endtask

    task automatic append_bytes(int e, int n);
        for (int i = 0; i < n; i++)
            send_item(cdbl_pkg::OP_APPEND, 16'($urandom), ent_bytes[e][i]);
    endtask

    task automatic lookup_key();
        send_item(cdbl_pkg::OP_LOOKUP, 16'($urandom), 8'($urandom));
    endtask

    task automatic random_key(int n);
        for (int i = 0; i < n; i++) send_item(cdbl_pkg::OP_APPEND, 16'($urandom), 8'($urandom));
    endtask

    task automatic put_word(int unsigned a, bit [31:0] v);
        for (int i = 0; i < 4; i++) send_item(cdbl_pkg::OP_WRITE, 16'(a + i), v[8*i +: 8]);
    endtask

    // Stops offering and waits until every lookup has answered and settled.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (lookup_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_ready(bit v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        image_ready = v;
    endtask

    // With the image not ready every lookup misses, even an over-long key.
    task automatic test_not_ready();
        set_ready(1'b0);
        lookup_key();
        random_key(KEY_MAX + 2);
        lookup_key();
        send_item(OP_UNUSED, 16'hFFFF, 8'hFF);
        send_item(cdbl_pkg::OP_WRITE, 16'hFFFF, 8'hFF);
        send_item(cdbl_pkg::OP_WRITE, 16'h0000, 8'h00);
        wait_drained();
    endtask

    task automatic load_image();
        for (int a = 0; a < 65536; a++)
            if (plan_set[a]) send_item(cdbl_pkg::OP_WRITE, 16'(a), plan_mem[a]);
        wait_drained();
        set_ready(1'b1);
    endtask

    // Empty key, key of the maximum length, a decoyed key, misses and overflow.
    task automatic test_directed_keys();
        lookup_key();
        append_bytes(PROBE_KEY, KEY_MAX);
        lookup_key();
        append_bytes(2, ent_len[2]);
        lookup_key();
        random_key(3);
        lookup_key();
        random_key(KEY_MAX + 1);
        lookup_key();
        append_bytes(4, ent_len[4]);
        send_item(OP_UNUSED, 16'h1234, 8'h5A);
        lookup_key();
    endtask

    // Damages the table of one key in four places, each repaired afterwards.
    task automatic test_format_errors();
        int unsigned head, slot, rec;
        head = (ent_hash[PROBE_KEY] % 256) * 8;
        slot = ent_slot[PROBE_KEY];
        rec  = ent_rec[PROBE_KEY];
        // Slot table running past the end of the image.
        put_word(head, 32'h0000_FFFC);
        append_bytes(PROBE_KEY, KEY_MAX);
        lookup_key();
        put_word(head, plan_word(head));
        // Record header past the end.
        put_word(slot + 4, 32'h0000_FFFC);
        append_bytes(PROBE_KEY, KEY_MAX);
        lookup_key();
        // Stored key past the end.
        put_word(16'hFFF0, KEY_MAX);
        put_word(16'hFFF4, 32'd0);
        put_word(slot + 4, 32'h0000_FFF0);
        append_bytes(PROBE_KEY, KEY_MAX);
        lookup_key();
        put_word(slot + 4, plan_word(slot + 4));
        // Value past the end.
        put_word(rec + 4, 32'hFFFF_0000);
        append_bytes(PROBE_KEY, KEY_MAX);
        lookup_key();
        put_word(rec + 4, plan_word(rec + 4));
        wait_drained();
    endtask

    // The receiver holds off while lookups keep coming, then the sender
    // pauses until everything has drained.
    task automatic test_backpressure();
        hold_req = 700;
        for (int i = 0; i < 8; i++) begin
            append_bytes(3 + i, ent_len[3 + i]);
            lookup_key();
        end
        wait_drained();
    endtask

    // Mostly well-formed lookups of stored keys, plus misses, truncated keys,
    // over-long keys, scratch writes and unused codes.
    task automatic test_random(int target);
        int k, pick;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, num_ents - 1);
            if (pick < 65) begin
                append_bytes(k, ent_len[k]);
                lookup_key();
            end else if (pick < 78) begin
                random_key($urandom_range(0, 20));
                lookup_key();
            end else if (pick < 84) begin
                append_bytes(k, (ent_len[k] == 0) ? 0 : $urandom_range(0, ent_len[k] - 1));
                lookup_key();
            end else if (pick < 88) begin
                random_key($urandom_range(KEY_MAX + 1, KEY_MAX + 4));
                lookup_key();
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 4))
                    send_item(cdbl_pkg::OP_WRITE, 16'($urandom_range(16'h8000, 16'hFFEF)),
                              8'($urandom));
            end else begin
                send_item(OP_UNUSED, 16'($urandom), 8'($urandom));
            end
        end
    endtask

    // Receiver: random stall bursts, or one long hold-off when asked.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                i_stall <= 1'b1;
                repeat (hold_req) @(posedge i_clk);
                hold_req = 0;
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Compares each result transfer with the oldest predicted answer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (lookup_answers.size() == 0) begin
                $error("result transfer with no lookup outstanding");
                fails++;
            end else begin
                got = lookup_answers.pop_front();
                if (o_status !== got.status) begin
                    $error("status: expected %0d, got %0d", got.status, o_status);
                    fails++;
                end
                if (o_value_offset !== got.offset) begin
                    $error("value_offset: expected %0d, got %0d", got.offset, o_value_offset);
                    fails++;
                end
                if (o_value_length !== got.length) begin
                    $error("value_length: expected %0d, got %0d", got.length, o_value_length);
                    fails++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("constant_db_hash_lookup_unit verification failed");
        $finish;
    end

    initial begin
        key_len     = 0;
        key_ovf     = 1'b0;
        key_hash    = cdbl_pkg::HASH_SEED;
        image_ready = 1'b0;
        build_plan();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_not_ready();
        load_image();
        test_directed_keys();
        test_format_errors();
        test_backpressure();
        test_random(items_sent + 200);
        wait_drained();
        set_ready(1'b0);
        test_random(items_sent + 40);
        wait_drained();
        set_ready(1'b1);
        test_random(items_sent + 80);
        quiet = 1'b1;
        test_random(items_sent + 80);
        wait_drained();
        if (fails == 0)
            $display("constant_db_hash_lookup_unit verification clean");
        else
            $display("constant_db_hash_lookup_unit verification failed");
        $finish;
    end

endmodule
